@@ sv/izu_pkg.sv @@
// Shared types, constants and the saturating helper function of the Izhikevich neuron update unit.
package izu_pkg;

  localparam int NEURON_COUNT = 1024;
  localparam int ADDR_W       = $clog2(NEURON_COUNT);
  localparam int IDX_W        = 10;
  localparam int FRAC_BITS    = 16;
  localparam int DATA_W       = 32;
  localparam int WIDE_W       = 64;

  localparam int IN_TDATA_W   = 48;
  localparam int OUT_TDATA_W  = 80;
  localparam int CFG_IDX_W    = 4;

  // queue depths are powers of two, pointers wrap
  localparam int IQ_DEPTH     = 4;
  localparam int IQ_PTR_W     = $clog2(IQ_DEPTH);
  localparam int IQ_CNT_W     = $clog2(IQ_DEPTH + 1);
  localparam int OQ_DEPTH     = 16;
  localparam int OQ_PTR_W     = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W     = $clog2(OQ_DEPTH + 1);

  localparam int PIPE_DEPTH   = 8;

  // divide by 100: arithmetic shift by 2, then magnitude times ceil(2^36/25)
  localparam int NUM_W        = DATA_W + 2;
  localparam int X_W          = DATA_W - 1;
  localparam int DIV_MUL_W    = 32;
  localparam int PROD_W       = X_W + DIV_MUL_W;
  localparam int DIV_SH       = 36;
  localparam int Q_W          = PROD_W - DIV_SH;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = 32'd2748779070;

  localparam logic signed [DATA_W-1:0] V_RESET = DATA_W'(-60 * (2 ** FRAC_BITS));
  localparam logic signed [WIDE_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [WIDE_W-1:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A     = 4'd0,
    CFG_B     = 4'd1,
    CFG_C     = 4'd2,
    CFG_D     = 4'd3,
    CFG_K     = 4'd4,
    CFG_VR    = 4'd5,
    CFG_VT    = 4'd6,
    CFG_VPEAK = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] c;
    logic signed [DATA_W-1:0] d;
    logic signed [DATA_W-1:0] k;
    logic signed [DATA_W-1:0] vr;
    logic signed [DATA_W-1:0] vt;
    logic signed [DATA_W-1:0] vpeak;
  } izu_cfg_t;

  localparam izu_cfg_t CFG_RESET = '{
    a:     32'sd1311,
    b:     32'sd32768,
    c:     -32'sd2621440,
    d:     32'sd6553600,
    k:     32'sd32768,
    vr:    -32'sd3932160,
    vt:    -32'sd2949120,
    vpeak: 32'sd2293760
  };

  typedef struct packed {
    logic                     vld;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] cur;
  } izu_item_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } izu_back_stat_t;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic                     spiked;
    logic signed [DATA_W-1:0] nv;
    logic signed [DATA_W-1:0] nu;
  } izu_result_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > SAT_MAX) begin
      r = SAT_MAX[DATA_W-1:0];
    end else if (x < SAT_MIN) begin
      r = SAT_MIN[DATA_W-1:0];
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ sv/izu_ram.sv @@
// Generic single-write, single-read RAM with registered read data (read returns old data).
module izu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/izu_front.sv @@
// Front end: accepts input transactions into a short queue ahead of the update pipeline.
module izu_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [izu_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  izu_pkg::izu_back_stat_t         stat,
  output izu_pkg::izu_item_t              head
);
  import izu_pkg::*;

  logic [IDX_W-1:0]    idx_q_r [IQ_DEPTH];
  logic [DATA_W-1:0]   cur_q_r [IQ_DEPTH];
  logic [IQ_PTR_W-1:0] wptr_r;
  logic [IQ_PTR_W-1:0] rptr_r;
  logic [IQ_CNT_W-1:0] cnt_r;
  logic                push;

  assign in_tready = (cnt_r != IQ_CNT_W'(IQ_DEPTH)) && !stat.busy;
  assign push      = in_tvalid && in_tready;

  assign head.vld  = (cnt_r != '0);
  assign head.idx  = idx_q_r[rptr_r];
  assign head.cur  = cur_q_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (stat.pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      cnt_r <= cnt_r + IQ_CNT_W'(push) - IQ_CNT_W'(stat.pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      idx_q_r[wptr_r] <= in_tdata[IDX_W-1:0];
      cur_q_r[wptr_r] <= in_tdata[IDX_W +: DATA_W];
    end
  end

endmodule

@@ sv/izu_back.sv @@
// Back end: state stores, clearing pass, repeat interlock and the Euler update pipeline.
module izu_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  izu_pkg::izu_cfg_t       cfg,
  input  izu_pkg::izu_item_t      head,
  output izu_pkg::izu_back_stat_t stat,
  input  logic                    oq_pop,
  output logic                    res_vld,
  output izu_pkg::izu_result_t    res
);
  import izu_pkg::*;

  logic                busy_r;
  logic [ADDR_W-1:0]   init_cnt_r;
  logic [OQ_CNT_W-1:0] credit_r;
  logic [OQ_CNT_W-1:0] credit_nxt;
  logic                hazard;
  logic                issue;

  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:1] spk_r;
  logic [IDX_W-1:0]      idx_r [PIPE_DEPTH];

  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic signed [DATA_W-1:0] v_wdata;
  logic signed [DATA_W-1:0] u_wdata;
  logic signed [DATA_W-1:0] v_rd;
  logic signed [DATA_W-1:0] u_rd;

  logic signed [DATA_W-1:0] s1_cur_r;
  logic signed [DATA_W-1:0] s2_v_r, s2_u_r, s2_cur_r, s2_dr_r, s2_dt_r;
  logic signed [DATA_W-1:0] s3_v_r, s3_u_r, s3_cur_r, s3_dt_r;
  logic signed [WIDE_W-1:0] s3_pk_r, s3_pb_r;
  logic signed [DATA_W-1:0] s4_v_r, s4_u_r, s4_cur_r, s4_dt_r, s4_p1_r, s4_q2_r;
  logic signed [DATA_W-1:0] s5_v_r, s5_u_r, s5_cur_r;
  logic signed [WIDE_W-1:0] s5_pp_r, s5_pa_r;
  logic signed [DATA_W-1:0] s6_v_r, s6_u_r, s6_nue_r;
  logic [X_W-1:0]           s6_x_r;
  logic                     s6_neg_r;
  logic signed [DATA_W-1:0] s7_v_r, s7_u_r, s7_nue_r;
  logic [PROD_W-1:0]        s7_prod_r;
  logic                     s7_neg_r;
  logic signed [DATA_W-1:0] s8_nv_r, s8_nu_r;

  logic signed [DATA_W-1:0] dr1, dt1;
  logic                     spk1;
  logic signed [WIDE_W-1:0] pk2, pb2;
  logic signed [DATA_W-1:0] p1_3, q1_3, q2_3;
  logic signed [WIDE_W-1:0] pp4, pa4;
  logic signed [DATA_W-1:0] p2_5, nue5;
  logic signed [NUM_W-1:0]  num5;
  logic [DATA_W-1:0]        m5;
  logic [X_W-1:0]           x5;
  logic [Q_W-1:0]           q7;
  logic signed [DATA_W-1:0] qs7, nve7, nv7, nu7;

  // interlock: a neuron still in flight is not read again until written back
  always_comb begin
    hazard = 1'b0;
    for (int i = 0; i < PIPE_DEPTH; i++) begin
      if (vld_r[i] && (idx_r[i] == head.idx)) begin
        hazard = 1'b1;
      end
    end
  end

  assign issue      = head.vld && !busy_r && !hazard && (credit_r != '0);
  assign credit_nxt = credit_r - OQ_CNT_W'(issue) + OQ_CNT_W'(oq_pop);
  assign stat.pop   = issue;
  assign stat.busy  = busy_r;

  assign mem_we    = busy_r || vld_r[PIPE_DEPTH-1];
  assign mem_waddr = busy_r ? init_cnt_r : idx_r[PIPE_DEPTH-1][ADDR_W-1:0];
  assign v_wdata   = busy_r ? V_RESET : s8_nv_r;
  assign u_wdata   = busy_r ? '0 : s8_nu_r;

  izu_ram #(.WIDTH(DATA_W), .DEPTH(NEURON_COUNT)) u_v_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (v_wdata),
    .raddr (head.idx[ADDR_W-1:0]),
    .rdata (v_rd)
  );

  izu_ram #(.WIDTH(DATA_W), .DEPTH(NEURON_COUNT)) u_u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (u_wdata),
    .raddr (head.idx[ADDR_W-1:0]),
    .rdata (u_rd)
  );

  always_comb begin
    dr1  = sat32(WIDE_W'(v_rd) - WIDE_W'(cfg.vr));
    dt1  = sat32(WIDE_W'(v_rd) - WIDE_W'(cfg.vt));
    spk1 = (v_rd > cfg.vpeak);

    pk2 = cfg.k * s2_dr_r;
    pb2 = cfg.b * s2_dr_r;

    p1_3 = sat32(s3_pk_r >>> FRAC_BITS);
    q1_3 = sat32(s3_pb_r >>> FRAC_BITS);
    q2_3 = sat32(WIDE_W'(q1_3) - WIDE_W'(s3_u_r));

    pp4 = s4_p1_r * s4_dt_r;
    pa4 = cfg.a * s4_q2_r;

    p2_5 = sat32(s5_pp_r >>> FRAC_BITS);
    num5 = NUM_W'(p2_5) - NUM_W'(s5_u_r) + NUM_W'(s5_cur_r);
    m5   = num5[NUM_W-1:2];
    x5   = m5[DATA_W-1] ? ~m5[X_W-1:0] : m5[X_W-1:0];
    nue5 = sat32((s5_pa_r >>> (FRAC_BITS + 1)) + WIDE_W'(s5_u_r));

    q7   = s7_prod_r[DIV_SH +: Q_W];
    qs7  = s7_neg_r ? ~DATA_W'(q7) : DATA_W'(q7);
    nve7 = sat32(WIDE_W'(s7_v_r) + WIDE_W'(qs7));
    nv7  = spk_r[PIPE_DEPTH-2] ? cfg.c : nve7;
    nu7  = spk_r[PIPE_DEPTH-2] ? sat32(WIDE_W'(s7_u_r) + WIDE_W'(cfg.d)) : s7_nue_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      init_cnt_r <= '0;
      credit_r   <= OQ_CNT_W'(OQ_DEPTH);
      vld_r      <= '0;
    end else begin
      if (busy_r) begin
        init_cnt_r <= init_cnt_r + 1'b1;
        if (init_cnt_r == ADDR_W'(NEURON_COUNT - 1)) begin
          busy_r <= 1'b0;
        end
      end
      credit_r <= credit_nxt;
      vld_r    <= {vld_r[PIPE_DEPTH-2:0], issue};
    end
  end

  always_ff @(posedge clk) begin
    idx_r[0] <= head.idx;
    for (int i = 1; i < PIPE_DEPTH; i++) begin
      idx_r[i] <= idx_r[i-1];
    end
    spk_r <= {spk_r[PIPE_DEPTH-2:1], spk1};

    s1_cur_r <= head.cur;

    s2_v_r   <= v_rd;
    s2_u_r   <= u_rd;
    s2_cur_r <= s1_cur_r;
    s2_dr_r  <= dr1;
    s2_dt_r  <= dt1;

    s3_v_r   <= s2_v_r;
    s3_u_r   <= s2_u_r;
    s3_cur_r <= s2_cur_r;
    s3_dt_r  <= s2_dt_r;
    s3_pk_r  <= pk2;
    s3_pb_r  <= pb2;

    s4_v_r   <= s3_v_r;
    s4_u_r   <= s3_u_r;
    s4_cur_r <= s3_cur_r;
    s4_dt_r  <= s3_dt_r;
    s4_p1_r  <= p1_3;
    s4_q2_r  <= q2_3;

    s5_v_r   <= s4_v_r;
    s5_u_r   <= s4_u_r;
    s5_cur_r <= s4_cur_r;
    s5_pp_r  <= pp4;
    s5_pa_r  <= pa4;

    s6_v_r   <= s5_v_r;
    s6_u_r   <= s5_u_r;
    s6_nue_r <= nue5;
    s6_x_r   <= x5;
    s6_neg_r <= m5[DATA_W-1];

    s7_v_r    <= s6_v_r;
    s7_u_r    <= s6_u_r;
    s7_nue_r  <= s6_nue_r;
    s7_prod_r <= PROD_W'(s6_x_r) * PROD_W'(DIV_MUL);
    s7_neg_r  <= s6_neg_r;

    s8_nv_r <= nv7;
    s8_nu_r <= nu7;
  end

  assign res_vld    = vld_r[PIPE_DEPTH-1];
  assign res.idx    = idx_r[PIPE_DEPTH-1];
  assign res.spiked = spk_r[PIPE_DEPTH-1];
  assign res.nv     = s8_nv_r;
  assign res.nu     = s8_nu_r;

endmodule

@@ sv/izu_outq.sv @@
// Result queue: holds finished updates until the downstream side takes them.
module izu_outq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  izu_pkg::izu_result_t            push_data,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [izu_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser
);
  import izu_pkg::*;

  izu_result_t         q_r [OQ_DEPTH];
  izu_result_t         head;
  logic [OQ_PTR_W-1:0] wptr_r;
  logic [OQ_PTR_W-1:0] rptr_r;
  logic [OQ_CNT_W-1:0] cnt_r;

  assign head       = q_r[rptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = OUT_TDATA_W'({head.nu, head.nv, head.idx});
  assign out_tuser  = head.spiked;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      cnt_r <= cnt_r + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= push_data;
    end
  end

endmodule

@@ sv/izhikevich_neuron_update_unit.sv @@
// Top level of the Izhikevich neuron update unit: configuration registers and block wiring.
//
// Input stream (in_*): one transaction names a neuron and its total input current.
// Output stream (out_*): one transaction per input, same order, carrying the neuron
// index, the new membrane and recovery values in tdata and the spike flag in tuser.
// Config channel (cfg_*): always ready; cfg_index selects a, b, c, d, k, vr, vt, vpeak
// (0 to 7), other indexes are dropped. Write only while no update is in flight.
// Throughput: one neuron per cycle while no neuron repeats within eight transactions
// and the result queue has free slots. A neuron issued again while an earlier update
// of it is in the 8-stage pipeline waits until that update is written back to the
// state RAMs.
// Reset: state RAMs are swept to V = -60, U = 0; in_tready stays low during the sweep
// while config writes are still taken.
// Output stall: finished results wait in a 16-entry queue; the pipeline issues only
// against free queue slots, so in_tready drops once the input queue fills.
module izhikevich_neuron_update_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // in_tdata: [9:0] neuron_index, [41:10] input_current, [47:42] zero
  input  logic [izu_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tdata: [9:0] out_index, [41:10] new_membrane, [73:42] new_recovery, [79:74] zero
  output logic [izu_pkg::OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: [0] spiked
  output logic                            out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [izu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [izu_pkg::DATA_W-1:0]      cfg_data
);
  import izu_pkg::*;

  izu_cfg_t       cfg_r;
  izu_item_t      head;
  izu_back_stat_t stat;
  izu_result_t    res;
  logic           res_vld;
  logic           oq_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_A:     cfg_r.a     <= cfg_data;
        CFG_B:     cfg_r.b     <= cfg_data;
        CFG_C:     cfg_r.c     <= cfg_data;
        CFG_D:     cfg_r.d     <= cfg_data;
        CFG_K:     cfg_r.k     <= cfg_data;
        CFG_VR:    cfg_r.vr    <= cfg_data;
        CFG_VT:    cfg_r.vt    <= cfg_data;
        CFG_VPEAK: cfg_r.vpeak <= cfg_data;
        default: ;
      endcase
    end
  end

  izu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .stat      (stat),
    .head      (head)
  );

  izu_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .head    (head),
    .stat    (stat),
    .oq_pop  (oq_pop),
    .res_vld (res_vld),
    .res     (res)
  );

  izu_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_vld),
    .push_data  (res),
    .pop        (oq_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ sv/izu_checker.sv @@
// Port-level checker for the Izhikevich neuron update unit, bound to the top level.
module izu_port_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [izu_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped before transaction");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_sweep_blocks_input: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready during state clearing");

  a_reset_no_result: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

endmodule

bind izhikevich_neuron_update_unit izu_port_checker u_izu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ test/izu_checker.sv @@
// Checker for the Izhikevich neuron update unit: predicts every update and compares results.
`timescale 1ns / 1ps
module izu_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [izu_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [izu_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            out_tuser,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [izu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [izu_pkg::DATA_W-1:0]      cfg_data,
  output int                              error_count,
  output int                              outstanding
);
  import izu_pkg::*;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam longint STEP_DIVISOR = 100;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic                     spiked;
    logic signed [DATA_W-1:0] membrane;
    logic signed [DATA_W-1:0] recovery;
  } neuron_update_t;

  logic signed [DATA_W-1:0] membrane_mem [0:NEURON_COUNT-1];
  logic signed [DATA_W-1:0] recovery_mem [0:NEURON_COUNT-1];
  longint par_a, par_b, par_c, par_d, par_k, par_vr, par_vt, par_vpeak;
  neuron_update_t expected_updates [$];

  function automatic longint clamp32(input longint x);
    if (x > Q_MAX) return Q_MAX;
    if (x < Q_MIN) return Q_MIN;
    return x;
  endfunction

  // exact product, floor toward minus infinity
  function automatic longint qmul(input longint x, input longint y);
    return (x * y) >>> FRAC_BITS;
  endfunction

  function automatic longint floor_div_step(input longint x);
    longint q;
    q = x / STEP_DIVISOR;
    if (x < 0 && (x % STEP_DIVISOR) != 0) q = q - 1;
    return q;
  endfunction

  function automatic neuron_update_t izh_update(input logic [IDX_W-1:0] idx,
                                                input longint cur);
    neuron_update_t r;
    longint v, u, nv, nu, dr, dt, p1, p2, q1, q2, q3;
    logic spk;
    v = membrane_mem[idx];
    u = recovery_mem[idx];
    spk = v > par_vpeak;
    if (spk) begin
      nv = par_c;
      nu = clamp32(u + par_d);
    end else begin
      dr = clamp32(v - par_vr);
      dt = clamp32(v - par_vt);
      p1 = clamp32(qmul(par_k, dr));
      p2 = clamp32(qmul(p1, dt));
      q1 = clamp32(qmul(par_b, dr));
      q2 = clamp32(q1 - u);
      q3 = qmul(par_a, q2);
      nv = clamp32(v + floor_div_step(p2 - u + cur));
      nu = clamp32(u + (q3 >>> 1));
    end
    membrane_mem[idx] = nv[DATA_W-1:0];
    recovery_mem[idx] = nu[DATA_W-1:0];
    r.idx = idx;
    r.spiked = spk;
    r.membrane = nv[DATA_W-1:0];
    r.recovery = nu[DATA_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    neuron_update_t exp_upd, got_upd;
    if (!rst_n) begin
      par_a = CFG_RESET.a;
      par_b = CFG_RESET.b;
      par_c = CFG_RESET.c;
      par_d = CFG_RESET.d;
      par_k = CFG_RESET.k;
      par_vr = CFG_RESET.vr;
      par_vt = CFG_RESET.vt;
      par_vpeak = CFG_RESET.vpeak;
      for (int n = 0; n < NEURON_COUNT; n++) begin
        membrane_mem[n] = V_RESET;
        recovery_mem[n] = '0;
      end
      expected_updates.delete();
      error_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_A:     par_a = $signed(cfg_data);
          CFG_B:     par_b = $signed(cfg_data);
          CFG_C:     par_c = $signed(cfg_data);
          CFG_D:     par_d = $signed(cfg_data);
          CFG_K:     par_k = $signed(cfg_data);
          CFG_VR:    par_vr = $signed(cfg_data);
          CFG_VT:    par_vt = $signed(cfg_data);
          CFG_VPEAK: par_vpeak = $signed(cfg_data);
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got_upd.idx = out_tdata[9:0];
        got_upd.spiked = out_tuser;
        got_upd.membrane = out_tdata[41:10];
        got_upd.recovery = out_tdata[73:42];
        if (expected_updates.size() == 0) begin
          $display("%0t: unexpected result, expected nothing, got idx=%0d spk=%0b v=%0d u=%0d",
                   $time, got_upd.idx, got_upd.spiked, got_upd.membrane, got_upd.recovery);
          error_count = error_count + 1;
        end else begin
          exp_upd = expected_updates.pop_front();
          if (got_upd !== exp_upd) begin
            $display("%0t: mismatch expected idx=%0d spk=%0b v=%0d u=%0d,",
                     $time, exp_upd.idx, exp_upd.spiked, exp_upd.membrane,
                     exp_upd.recovery);
            $display("%0t:          got idx=%0d spk=%0b v=%0d u=%0d",
                     $time, got_upd.idx, got_upd.spiked, got_upd.membrane,
                     got_upd.recovery);
            error_count = error_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        exp_upd = izh_update(in_tdata[9:0], $signed(in_tdata[41:10]));
        expected_updates.insert(expected_updates.size(), exp_upd);
      end
    end
    outstanding <= expected_updates.size();
  end

endmodule

@@ test/tb.sv @@
// Testbench top for the Izhikevich neuron update unit: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module tb;
  import izu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int DRAIN_CYCLES = 24;
  localparam logic [DATA_W-1:0] Q_MAX32 = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN32 = 32'h8000_0000;
  localparam logic [CFG_IDX_W-1:0] SPARE_REG = 4'd12;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [DATA_W-1:0]      cfg_data;
  int                     error_count;
  int                     outstanding;
  int                     cycles;
  int                     idle_pct;

  izhikevich_neuron_update_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  izu_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .error_count(error_count),
    .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** izhikevich_neuron_update_unit: FAILED **");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  task automatic wait_drained;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_current(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] cur);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
      repeat ($urandom_range(1, 14)) @(negedge clk);
    in_tdata = {6'd0, cur, idx};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_param(input logic [DATA_W-1:0] dflt,
                                                   input int kind);
    logic [DATA_W-1:0] r;
    case (kind)
      0: r = dflt;
      1: r = dflt + $urandom_range(0, 32'd655360) - 32'd327680;
      2: r = $urandom;
      default: begin
        case ($urandom_range(0, 4))
          0: r = Q_MAX32;
          1: r = Q_MIN32;
          2: r = '0;
          3: r = '1;
          default: r = dflt;
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_current();
    logic [DATA_W-1:0] r;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: r = $urandom;
      5: r = Q_MAX32;
      6: r = Q_MIN32;
      7: r = '0;
      8: r = '1;
      // mostly moderate drive, -50 to +1500 in Q16.16
      default: r = $urandom_range(0, 32'd101580800) - 32'd3276800;
    endcase
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    // a small hot set forces back-to-back repeats of the same neuron
    if ($urandom_range(0, 1) == 0) return IDX_W'($urandom_range(0, 7));
    return IDX_W'($urandom);
  endfunction

  task automatic load_params(input int kind);
    wait_drained();
    cfg_write(CFG_A, pick_param(CFG_RESET.a, kind));
    cfg_write(CFG_B, pick_param(CFG_RESET.b, kind));
    cfg_write(CFG_C, pick_param(CFG_RESET.c, kind));
    cfg_write(CFG_D, pick_param(CFG_RESET.d, kind));
    cfg_write(CFG_K, pick_param(CFG_RESET.k, kind));
    cfg_write(CFG_VR, pick_param(CFG_RESET.vr, kind));
    cfg_write(CFG_VT, pick_param(CFG_RESET.vt, kind));
    cfg_write(CFG_VPEAK, pick_param(CFG_RESET.vpeak, kind));
    cfg_write(CFG_IDX_W'($urandom_range(8, 15)), $urandom);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 20;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset configuration, field extremes, a neuron driven into a spike
    send_current(10'd0, '0);
    send_current(10'd1023, Q_MAX32);
    send_current(10'd1023, Q_MAX32);
    send_current(10'd1023, Q_MIN32);
    send_current(10'd1023, Q_MIN32);
    send_current(10'd3, Q_MIN32);
    send_current(10'd3, Q_MIN32);
    send_current(10'd3, Q_MIN32);
    send_current(10'd4, '1);
    send_current(10'd5, 32'd1);
    send_current(10'd512, 32'h5555_5555);
    send_current(10'd341, 32'hAAAA_AAAA);

    // spike straight from reset, repeated spikes, saturated recovery jump
    wait_drained();
    cfg_write(CFG_C, '0);
    cfg_write(CFG_D, Q_MAX32);
    cfg_write(CFG_VPEAK, V_RESET - 32'sd1);
    cfg_write(SPARE_REG, Q_MIN32);
    send_current(10'd700, '0);
    send_current(10'd700, '0);
    send_current(10'd700, Q_MAX32);
    send_current(10'd701, Q_MAX32);

    // membrane equal to peak does not spike; saturating intermediates
    wait_drained();
    cfg_write(CFG_A, Q_MIN32);
    cfg_write(CFG_B, Q_MAX32);
    cfg_write(CFG_K, Q_MAX32);
    cfg_write(CFG_VR, Q_MAX32);
    cfg_write(CFG_VT, Q_MIN32);
    cfg_write(CFG_VPEAK, V_RESET);
    cfg_write(CFG_C, Q_MIN32);
    cfg_write(CFG_D, Q_MIN32);
    send_current(10'd702, Q_MIN32);
    send_current(10'd703, Q_MAX32);
    send_current(10'd702, '0);
    send_current(10'd703, '1);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1 || ph % 3 == 1) idle_pct = 0;
      else idle_pct = 20;
      load_params(ph % 4);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (ph == 3 && i == ITEMS_PER_PHASE / 2) wait_drained();
        send_current(pick_index(), pick_current());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("** izhikevich_neuron_update_unit: PASSED **");
    end else begin
      $display("** izhikevich_neuron_update_unit: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/izu_pkg.sv
sv/izu_ram.sv
sv/izu_front.sv
sv/izu_back.sv
sv/izu_outq.sv
sv/izhikevich_neuron_update_unit.sv
sv/izu_checker.sv
test/izu_checker.sv
test/tb.sv
